/* src/rhs_pkg.sv */
// shared types, constants and helpers for the smoothed rgb histogram
`timescale 1ns / 1ps
package rhs_pkg;

  localparam int COUNT_WIDTH_DEF = 24;
  localparam int BIN_COUNT       = 256;
  localparam int BIN_W           = 8;
  localparam int CHANNELS        = 3;
  localparam int RAW_W           = 24;
  localparam int SUM_W           = 28;
  localparam int TAP_W           = 3;

  localparam logic [1:0] OP_ACCUM = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  // taps of the 1-4-6-4-1 kernel, lowest neighbor first
  localparam logic [TAP_W-1:0] TAP_OUTER_LO = 3'd0;
  localparam logic [TAP_W-1:0] TAP_INNER_LO = 3'd1;
  localparam logic [TAP_W-1:0] TAP_CENTER   = 3'd2;
  localparam logic [TAP_W-1:0] TAP_INNER_HI = 3'd3;
  localparam logic [TAP_W-1:0] TAP_OUTER_HI = 3'd4;

  typedef struct packed {
    logic             req;
    logic             inc;
    logic [BIN_W-1:0] addr;
  } bank_req_t;

  typedef struct packed {
    logic             we;
    logic [BIN_W-1:0] addr;
  } bank_clr_t;

  typedef struct packed {
    logic             valid;
    logic [TAP_W-1:0] tap;
  } tap_t;

  // neighbor bin for a tap, clamped to the edge bins
  function automatic logic [BIN_W-1:0] clamp_bin(input logic [BIN_W-1:0] bin,
                                                 input logic [TAP_W-1:0] tap);
    logic [BIN_W+1:0] pos;
    pos = {2'b00, bin} + (BIN_W+2)'(tap);
    if (pos < (BIN_W+2)'(2)) begin
      return '0;
    end else if (pos > (BIN_W+2)'(BIN_COUNT + 1)) begin
      return BIN_W'(BIN_COUNT - 1);
    end else begin
      return BIN_W'(pos - (BIN_W+2)'(2));
    end
  endfunction

endpackage

/* src/rhs_ram.sv */
// generic simple dual-port ram with registered read, read-first
`timescale 1ns / 1ps
module rhs_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/rhs_bank.sv */
// one channel of bins: ram plus saturating read-modify-write with forwarding
`timescale 1ns / 1ps
module rhs_bank #(
  parameter int COUNT_WIDTH = rhs_pkg::COUNT_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  rhs_pkg::bank_req_t     req,
  input  rhs_pkg::bank_clr_t     clr,
  output logic [COUNT_WIDTH-1:0] q
);
  import rhs_pkg::*;

  logic                   pend_valid;
  logic                   pend_inc;
  logic [BIN_W-1:0]       pend_addr;
  logic                   last_we;
  logic [BIN_W-1:0]       last_addr;
  logic [COUNT_WIDTH-1:0] last_data;
  logic [COUNT_WIDTH-1:0] ram_q;
  logic [COUNT_WIDTH-1:0] cur;
  logic [COUNT_WIDTH-1:0] inc_val;
  logic                   wr_en;
  logic [BIN_W-1:0]       wr_addr;
  logic [COUNT_WIDTH-1:0] wr_data;

  rhs_ram #(
    .WIDTH(COUNT_WIDTH),
    .DEPTH(BIN_COUNT)
  ) u_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata(wr_data),
    .raddr(req.addr),
    .rdata(ram_q)
  );

  // the ram returns old data when the same entry was written at the read edge
  always_comb begin
    if (pend_valid && last_we && (last_addr == pend_addr)) begin
      cur = last_data;
    end else begin
      cur = ram_q;
    end
    inc_val = (&cur) ? cur : cur + 1'b1;
    wr_en   = pend_inc | clr.we;
    wr_addr = clr.we ? clr.addr : pend_addr;
    wr_data = clr.we ? '0 : inc_val;
  end

  assign q = cur;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      pend_inc   <= 1'b0;
      last_we    <= 1'b0;
    end else begin
      pend_valid <= req.req;
      pend_inc   <= req.req & req.inc;
      last_we    <= wr_en;
    end
    pend_addr <= req.addr;
    last_addr <= wr_addr;
    last_data <= wr_data;
  end

endmodule

/* src/rhs_smooth.sv */
// weighted 1-4-6-4-1 accumulation over five bin reads, holds the result
`timescale 1ns / 1ps
module rhs_smooth #(
  parameter int COUNT_WIDTH = rhs_pkg::COUNT_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  rhs_pkg::tap_t                 tap,
  input  logic [COUNT_WIDTH-1:0]        data,
  output logic [rhs_pkg::RAW_W-1:0]     raw_count,
  output logic [rhs_pkg::SUM_W-1:0]     smoothed_sum,
  output logic                          result_valid
);
  import rhs_pkg::*;

  localparam int AccW = (COUNT_WIDTH + 4 > SUM_W) ? COUNT_WIDTH + 4 : SUM_W;
  localparam int RawW = (COUNT_WIDTH > RAW_W) ? COUNT_WIDTH : RAW_W;

  logic [AccW-1:0] acc;
  logic [AccW-1:0] acc_next;
  logic [AccW-1:0] ext;
  logic [AccW-1:0] term;
  logic [RawW-1:0] raw;

  always_comb begin
    ext = AccW'(data);
    case (tap.tap)
      TAP_OUTER_LO, TAP_OUTER_HI: term = ext;
      TAP_INNER_LO, TAP_INNER_HI: term = ext << 2;
      TAP_CENTER:                 term = (ext << 2) + (ext << 1);
      default:                    term = '0;
    endcase
    acc_next = (tap.tap == TAP_OUTER_LO) ? term : acc + term;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= tap.valid && (tap.tap == TAP_OUTER_HI);
    end
    if (tap.valid) begin
      acc <= acc_next;
      if (tap.tap == TAP_CENTER) begin
        raw <= RawW'(data);
      end
    end
  end

  assign raw_count    = raw[RAW_W-1:0];
  assign smoothed_sum = acc[SUM_W-1:0];

endmodule

/* src/rgb_histogram_smoothed.sv */
// three-channel 256-bin histogram with binomially smoothed bin reads
// accumulate: one pixel per cycle, busy stays low; bins written from the registered request
// read: busy through five tap reads (one bin read per cycle) and the wait state; result strobe
//   on result_valid for one cycle; the receiver cannot stall
// clear: busy while all 256 rows are zeroed, one row of bins (all three channels) per cycle
// reset (rst, synchronous): runs the same clear of all 256 rows before the first request is taken
`timescale 1ns / 1ps
module rgb_histogram_smoothed #(
  parameter int COUNT_WIDTH = rhs_pkg::COUNT_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      operation,
  input  logic [7:0]                      blue_value,
  input  logic [7:0]                      green_value,
  input  logic [7:0]                      red_value,
  input  logic [1:0]                      read_channel,
  input  logic [rhs_pkg::BIN_W-1:0]       read_bin,
  output logic [rhs_pkg::RAW_W-1:0]       raw_count,
  output logic [rhs_pkg::SUM_W-1:0]       smoothed_sum,
  output logic                            result_valid
);
  import rhs_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_READ  = 2'd1;
  localparam logic [1:0] ST_WAIT  = 2'd2;
  localparam logic [1:0] ST_CLEAR = 2'd3;

  logic [1:0]       state, state_next;
  logic [TAP_W-1:0] tap_cnt, tap_cnt_next;
  logic [BIN_W-1:0] clr_addr, clr_addr_next;
  logic [BIN_W-1:0] rd_bin;
  logic [1:0]       rd_ch;
  tap_t             tap_d;

  logic             accept;
  logic             acc_go;
  logic [BIN_W-1:0] tap_addr;
  bank_clr_t        clr;
  logic [CHANNELS-1:0][BIN_W-1:0]       pix;
  logic [CHANNELS-1:0][COUNT_WIDTH-1:0] q;
  logic [COUNT_WIDTH-1:0]               rd_data;

  assign busy     = (state != ST_IDLE);
  assign accept   = start && !busy;
  assign acc_go   = accept && (operation == OP_ACCUM);
  assign tap_addr = clamp_bin(rd_bin, tap_cnt);

  assign pix[CH_RED]   = red_value;
  assign pix[CH_GREEN] = green_value;
  assign pix[CH_BLUE]  = blue_value;

  assign clr.we   = (state == ST_CLEAR);
  assign clr.addr = clr_addr;

  for (genvar c = 0; c < CHANNELS; c++) begin : g_bank
    bank_req_t req;
    always_comb begin
      req.req  = acc_go || (state == ST_READ);
      req.inc  = acc_go;
      req.addr = (state == ST_READ) ? tap_addr : pix[c];
    end

    rhs_bank #(
      .COUNT_WIDTH(COUNT_WIDTH)
    ) u_bank (
      .clk(clk),
      .rst(rst),
      .req(req),
      .clr(clr),
      .q  (q[c])
    );
  end

  // unused channel code reads as zero
  always_comb begin
    case (rd_ch)
      CH_RED:   rd_data = q[CH_RED];
      CH_GREEN: rd_data = q[CH_GREEN];
      CH_BLUE:  rd_data = q[CH_BLUE];
      default:  rd_data = '0;
    endcase
  end

  always_comb begin
    state_next    = state;
    tap_cnt_next  = tap_cnt;
    clr_addr_next = clr_addr;
    case (state)
      ST_IDLE: begin
        if (accept && (operation == OP_READ)) begin
          state_next   = ST_READ;
          tap_cnt_next = TAP_OUTER_LO;
        end else if (accept && (operation == OP_CLEAR)) begin
          state_next    = ST_CLEAR;
          clr_addr_next = '0;
        end
      end
      ST_READ: begin
        if (tap_cnt == TAP_OUTER_HI) begin
          state_next = ST_WAIT;
        end else begin
          tap_cnt_next = tap_cnt + 1'b1;
        end
      end
      ST_WAIT: begin
        state_next = ST_IDLE;
      end
      ST_CLEAR: begin
        if (clr_addr == BIN_W'(BIN_COUNT - 1)) begin
          state_next = ST_IDLE;
        end
        clr_addr_next = clr_addr + 1'b1;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      tap_cnt     <= TAP_OUTER_LO;
      clr_addr    <= '0;
      tap_d.valid <= 1'b0;
    end else begin
      state       <= state_next;
      tap_cnt     <= tap_cnt_next;
      clr_addr    <= clr_addr_next;
      tap_d.valid <= (state == ST_READ);
    end
    tap_d.tap <= tap_cnt;
    if (accept && (operation == OP_READ)) begin
      rd_bin <= read_bin;
      rd_ch  <= read_channel;
    end
  end

  rhs_smooth #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_smooth (
    .clk         (clk),
    .rst         (rst),
    .tap         (tap_d),
    .data        (rd_data),
    .raw_count   (raw_count),
    .smoothed_sum(smoothed_sum),
    .result_valid(result_valid)
  );

endmodule

/* verif/tb_top.sv */
// self-checking testbench for the smoothed rgb histogram
`timescale 1ns / 1ps
module tb_top;
  import rhs_pkg::*;

  // counters narrower than the default width
  localparam int CNT_W = 16;
  localparam logic [31:0] CNT_MAX = (32'd1 << CNT_W) - 32'd1;
  localparam logic [1:0] OP_NONE = 2'd3;
  localparam logic [1:0] CH_NONE = 2'd3;
  localparam int RANDOM_REQUESTS = 600;
  localparam int REPEAT_PIXELS = 20;

  typedef struct {
    logic [RAW_W-1:0] raw;
    logic [SUM_W-1:0] sum;
  } bin_read_t;

  typedef struct packed {
    logic [1:0]       op;
    logic [7:0]       blue;
    logic [7:0]       green;
    logic [7:0]       red;
    logic [1:0]       ch;
    logic [BIN_W-1:0] bin;
    logic             typed;
    logic [RAW_W-1:0] raw;
    logic [SUM_W-1:0] sum;
  } stim_row_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  logic [1:0]       operation = OP_ACCUM;
  logic [7:0]       blue_value = '0;
  logic [7:0]       green_value = '0;
  logic [7:0]       red_value = '0;
  logic [1:0]       read_channel = CH_RED;
  logic [BIN_W-1:0] read_bin = '0;
  logic [RAW_W-1:0] raw_count;
  logic [SUM_W-1:0] smoothed_sum;
  logic             result_valid;

  // typed-in expectation for the request currently on the ports
  logic             use_typed = 1'b0;
  logic [RAW_W-1:0] typed_raw = '0;
  logic [SUM_W-1:0] typed_sum = '0;

  logic [31:0] bin_tally [CHANNELS][BIN_COUNT];
  bin_read_t   read_results_due [$];
  int          errors = 0;
  bit          quiet = 1'b0;

  stim_row_t directed_rows [25];

  always #5 clk = ~clk;

  rgb_histogram_smoothed #(.COUNT_WIDTH(CNT_W)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .operation(operation), .blue_value(blue_value), .green_value(green_value),
    .red_value(red_value), .read_channel(read_channel), .read_bin(read_bin),
    .raw_count(raw_count), .smoothed_sum(smoothed_sum), .result_valid(result_valid)
  );

  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic void flag_error(string msg);
    errors++;
    if (errors <= 10) $display("%0t: %s", $time, msg);
  endfunction

  function automatic logic [31:0] tally_at(int ch, int b);
    if (b < 0) b = 0;
    if (b > BIN_COUNT - 1) b = BIN_COUNT - 1;
    return bin_tally[ch][b];
  endfunction

  function automatic void bump_bin(int ch, logic [7:0] value);
    if (bin_tally[ch][value] < CNT_MAX) bin_tally[ch][value] = bin_tally[ch][value] + 1;
  endfunction

  function automatic void clear_tally();
    for (int c = 0; c < CHANNELS; c++)
      for (int b = 0; b < BIN_COUNT; b++) bin_tally[c][b] = '0;
  endfunction

  // applies one accepted request to the predicted histogram
  function automatic void apply_request();
    bin_read_t  rd;
    int         ch;
    int         b;
    logic [35:0] acc;
    case (operation)
      OP_ACCUM: begin
        bump_bin(int'(CH_BLUE), blue_value);
        bump_bin(int'(CH_GREEN), green_value);
        bump_bin(int'(CH_RED), red_value);
      end
      OP_CLEAR: clear_tally();
      OP_READ: begin
        ch = int'(read_channel);
        b = int'(read_bin);
        rd.raw = '0;
        rd.sum = '0;
        if (read_channel != CH_NONE) begin
          acc = 36'(tally_at(ch, b - 2)) + 36'(4 * tally_at(ch, b - 1))
              + 36'(6 * tally_at(ch, b)) + 36'(4 * tally_at(ch, b + 1))
              + 36'(tally_at(ch, b + 2));
          rd.raw = RAW_W'(tally_at(ch, b));
          rd.sum = SUM_W'(acc);
        end
        if (use_typed) begin
          rd.raw = typed_raw;
          rd.sum = typed_sum;
        end
        read_results_due.push_back(rd);
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    bin_read_t e;
    if (!rst) begin
      if (result_valid) begin
        if (read_results_due.size() == 0) begin
          flag_error($sformatf("unexpected result raw=%0d sum=%0d", raw_count, smoothed_sum));
        end else begin
          e = read_results_due.pop_front();
          if (raw_count !== e.raw)
            flag_error($sformatf("raw_count exp %0d got %0d", e.raw, raw_count));
          if (smoothed_sum !== e.sum)
            flag_error($sformatf("smoothed_sum exp %0d got %0d", e.sum, smoothed_sum));
        end
      end
      if (start && !busy) apply_request();
    end
  end

  // idle cycles with noise on the request fields
  task automatic idle(int n);
    repeat (n) begin
      start = 1'b0;
      use_typed = 1'b0;
      operation = 2'($urandom);
      blue_value = 8'($urandom);
      green_value = 8'($urandom);
      red_value = 8'($urandom);
      read_channel = 2'($urandom);
      read_bin = BIN_W'($urandom);
      @(negedge clk);
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // entered and left at a falling edge
  task automatic issue(stim_row_t row, int gap);
    start = 1'b1;
    operation = row.op;
    blue_value = row.blue;
    green_value = row.green;
    red_value = row.red;
    read_channel = row.ch;
    read_bin = row.bin;
    use_typed = row.typed;
    typed_raw = row.raw;
    typed_sum = row.sum;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    idle(gap);
  endtask

  function automatic stim_row_t mk(logic [1:0] op, logic [7:0] b, logic [7:0] g,
                                   logic [7:0] r, logic [1:0] ch, logic [7:0] bin,
                                   logic typed, logic [31:0] raw, logic [31:0] sum);
    stim_row_t row;
    row.op = op;
    row.blue = b;
    row.green = g;
    row.red = r;
    row.ch = ch;
    row.bin = bin;
    row.typed = typed;
    row.raw = RAW_W'(raw);
    row.sum = SUM_W'(sum);
    return row;
  endfunction

  function automatic logic [7:0] pick_byte(logic [7:0] center);
    int r;
    r = $urandom_range(0, 3);
    if (r == 0) return 8'($urandom);
    if (r == 1) begin
      case ($urandom_range(0, 5))
        0: return 8'd0;
        1: return 8'd1;
        2: return 8'd2;
        3: return 8'd253;
        4: return 8'd254;
        default: return 8'd255;
      endcase
    end
    return center + 8'($urandom_range(0, 6)) - 8'd3;
  endfunction

  initial begin
    stim_row_t row;
    int        r;
    int        sent;
    logic [7:0] center;

    clear_tally();
    directed_rows = '{
      mk(OP_READ,  8'h00, 8'h00, 8'h00, CH_RED,   8'h00, 1'b1, 0, 0),
      mk(OP_READ,  8'h00, 8'h00, 8'h00, CH_BLUE,  8'hFF, 1'b1, 0, 0),
      mk(OP_READ,  8'h00, 8'h00, 8'h00, CH_NONE,  8'h80, 1'b1, 0, 0),
      mk(OP_ACCUM, 8'hFF, 8'h00, 8'hAA, CH_RED,   8'h00, 1'b0, 0, 0),
      mk(OP_ACCUM, 8'hFF, 8'h00, 8'h55, CH_RED,   8'h00, 1'b0, 0, 0),
      // edge bins: clamped neighbors count the edge bin again
      mk(OP_READ,  8'h00, 8'h00, 8'h00, CH_BLUE,  8'hFF, 1'b1, 2, 22),
      mk(OP_READ,  8'h00, 8'h00, 8'h00, CH_GREEN, 8'h00, 1'b1, 2, 22),
      mk(OP_READ,  8'h00, 8'h00, 8'h00, CH_GREEN, 8'h01, 1'b0, 0, 0),
      mk(OP_READ,  8'h00, 8'h00, 8'h00, CH_GREEN, 8'h02, 1'b0, 0, 0),
      mk(OP_READ,  8'h00, 8'h00, 8'h00, CH_BLUE,  8'hFE, 1'b0, 0, 0),
      mk(OP_READ,  8'h00, 8'h00, 8'h00, CH_RED,   8'hAA, 1'b0, 0, 0),
      mk(OP_READ,  8'h00, 8'h00, 8'h00, CH_RED,   8'hAC, 1'b0, 0, 0),
      mk(OP_NONE,  8'hFF, 8'hFF, 8'hFF, CH_BLUE,  8'hFF, 1'b0, 0, 0),
      mk(OP_READ,  8'h00, 8'h00, 8'h00, CH_RED,   8'hFF, 1'b1, 0, 0),
      mk(OP_READ,  8'h00, 8'h00, 8'h00, CH_NONE,  8'h00, 1'b1, 0, 0),
      mk(OP_ACCUM, 8'h00, 8'hFF, 8'h00, CH_RED,   8'h00, 1'b0, 0, 0),
      mk(OP_ACCUM, 8'h01, 8'hFE, 8'hFF, CH_RED,   8'h00, 1'b0, 0, 0),
      mk(OP_READ,  8'h00, 8'h00, 8'h00, CH_RED,   8'h00, 1'b0, 0, 0),
      mk(OP_READ,  8'h00, 8'h00, 8'h00, CH_GREEN, 8'hFE, 1'b0, 0, 0),
      mk(OP_CLEAR, 8'h00, 8'h00, 8'h00, CH_RED,   8'h00, 1'b0, 0, 0),
      mk(OP_READ,  8'h00, 8'h00, 8'h00, CH_BLUE,  8'hFF, 1'b1, 0, 0),
      mk(OP_READ,  8'h00, 8'h00, 8'h00, CH_GREEN, 8'h00, 1'b1, 0, 0),
      mk(OP_ACCUM, 8'h80, 8'h7F, 8'h01, CH_RED,   8'h00, 1'b0, 0, 0),
      mk(OP_READ,  8'h00, 8'h00, 8'h00, CH_RED,   8'h02, 1'b0, 0, 0),
      mk(OP_READ,  8'h00, 8'h00, 8'h00, CH_GREEN, 8'h7D, 1'b0, 0, 0)
    };

    repeat (6) @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[i]) issue(directed_rows[i], pick_gap());

    // repeated pixels on the same bins, back to back
    issue(mk(OP_CLEAR, 8'h00, 8'h00, 8'h00, CH_RED, 8'h00, 1'b0, 0, 0), 0);
    for (int i = 0; i < REPEAT_PIXELS; i++)
      issue(mk(OP_ACCUM, 8'h10, 8'hFF, 8'h00, CH_RED, 8'h00, 1'b0, 0, 0), 0);
    issue(mk(OP_READ, 8'h00, 8'h00, 8'h00, CH_BLUE, 8'h10, 1'b0, 0, 0), 1);
    issue(mk(OP_READ, 8'h00, 8'h00, 8'h00, CH_GREEN, 8'hFF, 1'b0, 0, 0), 0);
    issue(mk(OP_READ, 8'h00, 8'h00, 8'h00, CH_RED, 8'h01, 1'b0, 0, 0), 0);
    issue(mk(OP_READ, 8'h00, 8'h00, 8'h00, CH_RED, 8'h00, 1'b0, 0, 0), 2);

    sent = 0;
    center = 8'($urandom);
    while (sent < RANDOM_REQUESTS) begin
      if (sent % 50 == 0) begin
        quiet = ($urandom_range(0, 3) == 0);
        center = 8'($urandom);
      end
      r = $urandom_range(0, 99);
      row = mk(OP_ACCUM, pick_byte(center), pick_byte(center), pick_byte(center),
               CH_RED, pick_byte(center), 1'b0, 0, 0);
      row.ch = ($urandom_range(0, 11) == 0) ? CH_NONE : 2'($urandom_range(0, 2));
      if (r < 56) row.op = OP_ACCUM;
      else if (r < 92) row.op = OP_READ;
      else if (r < 95) row.op = OP_CLEAR;
      else row.op = OP_NONE;
      // ignored requests do not count toward the total
      if (row.op != OP_NONE) sent++;
      issue(row, pick_gap());
    end

    idle(1);
    while (read_results_due.size() != 0) @(negedge clk);
    idle(20);

    if (errors == 0 && read_results_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* files.f */
src/rhs_pkg.sv
src/rhs_ram.sv
src/rhs_bank.sv
src/rhs_smooth.sv
src/rgb_histogram_smoothed.sv
verif/tb_top.sv
